// File: src/odgs_pkg.sv
// Shared constants, codes and controller/datapath types of the gait scheduler.
`timescale 1ns / 1ps
`default_nettype none

package odgs_pkg;

  // Fixed field widths of the block's interface.
  localparam int LEG_COUNT        = 4;
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int FRAC_W           = 16;
  localparam int LEG_FIELD_W      = 6;
  localparam int SEG_W            = 6;
  localparam int IPS_W            = 10;
  localparam int PERIOD_W         = SEG_W + IPS_W;
  localparam int IT_W             = 32;
  localparam int DIVIDEND_W       = 32;
  localparam int STEP_W           = 6;
  localparam int CFG_W            = LEG_COUNT * LEG_FIELD_W;
  localparam int CFG_IDX_W        = 2;
  localparam int LEG_IDX_W        = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
  localparam int ROW_OUT_W        = 5;
  localparam int SEG_OUT_W        = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IPS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSETS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DURATIONS = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIV_REM,
    OP_DIV_SEG,
    OP_DIV_OFF,
    OP_PHASE,
    OP_DIV_ST,
    OP_SWPH,
    OP_DIV_SW,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [LEG_IDX_W-1:0] leg;
  } odgs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_row;
  } odgs_status_t;

endpackage

`default_nettype wire

// File: src/odgs_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, for the gait scheduler.
`timescale 1ns / 1ps
`default_nettype none

module odgs_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [odgs_pkg::DIVIDEND_W-1:0] dividend_i,
  input  wire logic [odgs_pkg::PERIOD_W-1:0]   divisor_i,
  input  wire logic [odgs_pkg::STEP_W-1:0]     steps_i,
  output logic                                 done_o,
  output logic [odgs_pkg::DIVIDEND_W-1:0]      quotient_o,
  output logic [odgs_pkg::PERIOD_W-1:0]        remainder_o
);
  import odgs_pkg::*;

  logic [DIVIDEND_W-1:0] q_q, q_d;
  logic [PERIOD_W-1:0]   r_q, r_d;
  logic [PERIOD_W-1:0]   d_q;
  logic [STEP_W-1:0]     cnt_q;
  logic                  busy_q, done_q;
  logic [PERIOD_W:0]     rs;
  logic                  ge;

  // The dividend is left aligned so that its top steps_i bits are consumed.
  always_comb begin
    rs  = {r_q, q_q[DIVIDEND_W-1]};
    ge  = (rs >= {1'b0, d_q});
    r_d = ge ? PERIOD_W'(rs - {1'b0, d_q}) : rs[PERIOD_W-1:0];
    q_d = {q_q[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = q_q;
  assign remainder_o = r_q;

endmodule

`default_nettype wire

// File: src/odgs_ctrl.sv
// Sequencing state machine of the gait scheduler.
`timescale 1ns / 1ps
`default_nettype none

module odgs_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  input  wire odgs_pkg::odgs_status_t status_i,
  output odgs_pkg::odgs_cmd_t         cmd_o,
  output logic                        busy
);
  import odgs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]           state_q, state_d;
  op_e                  ph_q, ph_d;
  logic [LEG_IDX_W-1:0] leg_q, leg_d;

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    leg_d     = leg_q;
    cmd_o.op  = OP_NONE;
    cmd_o.leg = leg_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = OP_CAPTURE;
          ph_d     = OP_DIV_REM;
          leg_d    = '0;
          state_d  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.op = ph_q;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.div_done) begin
          case (ph_q)
            OP_DIV_REM: begin
              ph_d    = OP_DIV_SEG;
              state_d = S_ISSUE;
            end
            OP_DIV_SEG: begin
              ph_d    = OP_DIV_OFF;
              state_d = S_ISSUE;
            end
            OP_DIV_OFF: begin
              ph_d    = OP_PHASE;
              state_d = S_STEP;
            end
            OP_DIV_ST: begin
              ph_d    = OP_SWPH;
              state_d = S_STEP;
            end
            OP_DIV_SW: begin
              if (leg_q == LEG_IDX_W'(LEG_COUNT - 1)) begin
                state_d = S_EMIT;
              end else begin
                leg_d   = leg_q + LEG_IDX_W'(1);
                ph_d    = OP_DIV_OFF;
                state_d = S_ISSUE;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_STEP: begin
        cmd_o.op = ph_q;
        ph_d     = (ph_q == OP_PHASE) ? OP_DIV_ST : OP_DIV_SW;
        state_d  = S_ISSUE;
      end
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        if (status_i.last_row) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= OP_NONE;
      leg_q   <= '0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      leg_q   <= leg_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: src/odgs_dp.sv
// Datapath of the gait scheduler: configuration, phase arithmetic and row output.
`timescale 1ns / 1ps
`default_nettype none

module odgs_dp #(
  parameter int MAX_SEGMENTS = odgs_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic                                            cfg_we_i,
  input  wire logic [odgs_pkg::CFG_IDX_W-1:0]                  cfg_index_i,
  input  wire logic [odgs_pkg::CFG_W-1:0]                      cfg_data_i,
  input  wire logic [odgs_pkg::IT_W-1:0]                       current_iteration_i,
  input  wire odgs_pkg::odgs_cmd_t                             cmd_i,
  output odgs_pkg::odgs_status_t                               status_o,
  output logic                                                 valid_o,
  output logic [odgs_pkg::ROW_OUT_W-1:0]                       row_index_o,
  output logic [odgs_pkg::LEG_COUNT-1:0]                       contact_mask_o,
  output logic [odgs_pkg::LEG_COUNT-1:0][odgs_pkg::FRAC_W-1:0] stance_o,
  output logic [odgs_pkg::LEG_COUNT-1:0][odgs_pkg::FRAC_W-1:0] swing_o,
  output logic [odgs_pkg::SEG_OUT_W-1:0]                       gait_segment_o,
  output logic                                                 last_row_o
);
  import odgs_pkg::*;

  localparam int ROW_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  // Configuration registers.
  logic [SEG_W-1:0] seg_cfg_q;
  logic [IPS_W-1:0] ips_cfg_q;
  logic [CFG_W-1:0] offs_cfg_q;
  logic [CFG_W-1:0] durs_cfg_q;

  // Working registers.
  logic [IT_W-1:0]     it_q;
  logic [PERIOD_W-1:0] period_q, rem_q, p_q, len_q;
  logic [SEG_W-1:0]    seg_q, t_q;
  logic [SEG_W-1:0]    off_q [LEG_COUNT];
  logic [SEG_W-1:0]    dur_q [LEG_COUNT];
  logic [LEG_COUNT-1:0][FRAC_W-1:0] st_q, sw_q;
  logic [ROW_W-1:0]    row_q;
  op_e                 dest_q;

  // Output registers.
  logic                 valid_q, last_q;
  logic [ROW_OUT_W-1:0] row_out_q;
  logic [LEG_COUNT-1:0] mask_q;

  logic [SEG_W-1:0]      n_eff;
  logic [IPS_W-1:0]      ips_eff;
  logic                  div_start, div_done;
  logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
  logic [PERIOD_W-1:0]   div_divisor, div_remainder;
  logic [STEP_W-1:0]     div_steps;
  logic [PERIOD_W-1:0]   off_ips, dur_ips, po_next, sw_base, ps_next;
  logic [FRAC_W-1:0]     frac;
  logic [SEG_W-1:0]      leg_dist [LEG_COUNT];
  logic [LEG_COUNT-1:0]  mask_d;
  logic [SEG_W-1:0]      row_ext, t_inc;
  logic                  row_last;
  logic [LEG_FIELD_W-1:0] off_field;

  // Out-of-range settings fold onto the nearest legal value.
  always_comb begin
    if (seg_cfg_q == '0) begin
      n_eff = SEG_W'(1);
    end else if ({1'b0, seg_cfg_q} > (SEG_W + 1)'(MAX_SEGMENTS)) begin
      n_eff = SEG_W'(MAX_SEGMENTS);
    end else begin
      n_eff = seg_cfg_q;
    end
    ips_eff = (ips_cfg_q == '0) ? IPS_W'(1) : ips_cfg_q;
  end

  // Divider operand selection.
  always_comb begin
    off_field    = offs_cfg_q[cmd_i.leg * LEG_FIELD_W +: LEG_FIELD_W];
    div_start    = 1'b0;
    div_dividend = it_q;
    div_divisor  = period_q;
    div_steps    = STEP_W'(DIVIDEND_W);
    case (cmd_i.op)
      OP_DIV_REM: begin
        div_start = 1'b1;
      end
      OP_DIV_SEG: begin
        div_start    = 1'b1;
        div_dividend = {rem_q, (DIVIDEND_W - PERIOD_W)'(0)};
        div_divisor  = PERIOD_W'(ips_eff);
        div_steps    = STEP_W'(PERIOD_W);
      end
      OP_DIV_OFF: begin
        div_start    = 1'b1;
        div_dividend = {off_field, (DIVIDEND_W - LEG_FIELD_W)'(0)};
        div_divisor  = PERIOD_W'(n_eff);
        div_steps    = STEP_W'(LEG_FIELD_W);
      end
      OP_DIV_ST, OP_DIV_SW: begin
        div_start    = 1'b1;
        div_dividend = {p_q, FRAC_W'(0)};
        div_divisor  = len_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  odgs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quotient_o (div_quotient),
    .remainder_o(div_remainder)
  );

  // Phase positions within the cycle, in iterations.
  always_comb begin
    off_ips = PERIOD_W'(off_q[cmd_i.leg]) * PERIOD_W'(ips_eff);
    dur_ips = PERIOD_W'(dur_q[cmd_i.leg]) * PERIOD_W'(ips_eff);
    if (rem_q >= off_ips) begin
      po_next = rem_q - off_ips;
    end else begin
      po_next = PERIOD_W'(({1'b0, rem_q} + {1'b0, period_q}) - {1'b0, off_ips});
    end
    sw_base = (len_q == period_q) ? '0 : len_q;
    if (p_q >= sw_base) begin
      ps_next = p_q - sw_base;
    end else begin
      ps_next = PERIOD_W'(({1'b0, p_q} + {1'b0, period_q}) - {1'b0, sw_base});
    end
  end

  // Progress is zero for an empty phase or outside it, and a full phase saturates.
  always_comb begin
    if (len_q == '0 || p_q > len_q) begin
      frac = '0;
    end else if (div_quotient[DIVIDEND_W-1:FRAC_W] != '0) begin
      frac = '1;
    end else begin
      frac = div_quotient[FRAC_W-1:0];
    end
  end

  // Contact test of the current row for every leg.
  always_comb begin
    mask_d = '0;
    for (int j = 0; j < LEG_COUNT; j++) begin
      if (t_q >= off_q[j]) begin
        leg_dist[j] = t_q - off_q[j];
      end else begin
        leg_dist[j] = SEG_W'(t_q + n_eff - off_q[j]);
      end
      mask_d[j] = (leg_dist[j] < dur_q[j]);
    end
    row_ext  = SEG_W'(row_q);
    row_last = (row_ext == n_eff - SEG_W'(1));
    t_inc    = t_q + SEG_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cfg_q  <= SEG_W'(10);
      ips_cfg_q  <= IPS_W'(1);
      offs_cfg_q <= '0;
      durs_cfg_q <= '0;
      valid_q    <= 1'b0;
      dest_q     <= OP_NONE;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SEGMENTS:  seg_cfg_q  <= cfg_data_i[SEG_W-1:0];
          REG_IPS:       ips_cfg_q  <= cfg_data_i[IPS_W-1:0];
          REG_OFFSETS:   offs_cfg_q <= cfg_data_i;
          REG_DURATIONS: durs_cfg_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      valid_q <= (cmd_i.op == OP_EMIT);
      if (div_start) begin
        dest_q <= cmd_i.op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        it_q     <= current_iteration_i;
        period_q <= PERIOD_W'(n_eff) * PERIOD_W'(ips_eff);
        row_q    <= '0;
        for (int j = 0; j < LEG_COUNT; j++) begin
          if (durs_cfg_q[j * LEG_FIELD_W +: LEG_FIELD_W] > n_eff) begin
            dur_q[j] <= n_eff;
          end else begin
            dur_q[j] <= durs_cfg_q[j * LEG_FIELD_W +: LEG_FIELD_W];
          end
        end
      end
      OP_PHASE: begin
        p_q   <= po_next;
        len_q <= dur_ips;
      end
      OP_SWPH: begin
        p_q   <= ps_next;
        len_q <= period_q - len_q;
      end
      OP_EMIT: begin
        row_out_q <= row_ext[ROW_OUT_W-1:0];
        mask_q    <= mask_d;
        last_q    <= row_last;
        row_q     <= row_q + ROW_W'(1);
        t_q       <= (t_inc == n_eff) ? '0 : t_inc;
      end
      default: begin
      end
    endcase
    if (div_done) begin
      case (dest_q)
        OP_DIV_REM: rem_q             <= div_remainder;
        OP_DIV_SEG: begin
          seg_q <= div_quotient[SEG_W-1:0];
          t_q   <= div_quotient[SEG_W-1:0];
        end
        OP_DIV_OFF: off_q[cmd_i.leg] <= div_remainder[SEG_W-1:0];
        OP_DIV_ST:  st_q[cmd_i.leg]  <= frac;
        OP_DIV_SW:  sw_q[cmd_i.leg]  <= frac;
        default: begin
        end
      endcase
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.last_row = row_last;
  assign valid_o           = valid_q;
  assign row_index_o       = row_out_q;
  assign contact_mask_o    = mask_q;
  assign stance_o          = st_q;
  assign swing_o           = sw_q;
  assign gait_segment_o    = seg_q[SEG_OUT_W-1:0];
  assign last_row_o        = last_q;

endmodule

`default_nettype wire

// File: src/offset_duration_gait_scheduler.sv
// Top level of the four-leg offset/duration gait contact scheduler.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request beat is taken at a rising edge where start is high and busy is low; it carries
// the absolute controller iteration count. The block then works out the cycle remainder,
// the current segment, each leg's folded offset and its stance and swing progress with one
// shared bit-per-cycle divider, and afterwards emits one result beat per horizon row.
// Each result beat is on the result ports for exactly one cycle, flagged by result_valid_o,
// and the receiver cannot hold it off. Rows come out in order 0 to N-1 on consecutive
// cycles, and last_row_o flags row N-1, where N is the folded segment count.
// The divider develops 32, 16 or 6 quotient bits per division. busy stays high until
// the sequencer has issued the last row, so a new request is taken only after that.
// Configuration is a plain write port (index 0 segments, 1 iterations per segment,
// 2 packed offsets, 3 packed durations); the user must write it only while the block
// is idle, since the block itself does not enforce this.
// Reset sets 10 segments, one iteration per segment, zero offsets and durations, and
// returns the sequencer to idle with no result pending.
module offset_duration_gait_scheduler #(
  parameter int MAX_SEGMENTS = odgs_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [odgs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [odgs_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [odgs_pkg::IT_W-1:0]         current_iteration_i,
  output logic                                   result_valid_o,
  output logic [odgs_pkg::ROW_OUT_W-1:0]         row_index_o,
  output logic [odgs_pkg::LEG_COUNT-1:0]         contact_mask_o,
  output logic [odgs_pkg::FRAC_W-1:0]            stance_progress_0_o,
  output logic [odgs_pkg::FRAC_W-1:0]            stance_progress_1_o,
  output logic [odgs_pkg::FRAC_W-1:0]            stance_progress_2_o,
  output logic [odgs_pkg::FRAC_W-1:0]            stance_progress_3_o,
  output logic [odgs_pkg::FRAC_W-1:0]            swing_progress_0_o,
  output logic [odgs_pkg::FRAC_W-1:0]            swing_progress_1_o,
  output logic [odgs_pkg::FRAC_W-1:0]            swing_progress_2_o,
  output logic [odgs_pkg::FRAC_W-1:0]            swing_progress_3_o,
  output logic [odgs_pkg::SEG_OUT_W-1:0]         gait_segment_o,
  output logic                                   last_row_o
);
  import odgs_pkg::*;

  odgs_cmd_t    cmd;
  odgs_status_t status;
  logic [LEG_COUNT-1:0][FRAC_W-1:0] stance, swing;

  // The sequencer walks the divisions and row emission; it owns busy.
  odgs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .status_i(status),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  // The datapath holds configuration, the shared divider and the result registers.
  odgs_dp #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .current_iteration_i(current_iteration_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .valid_o            (result_valid_o),
    .row_index_o        (row_index_o),
    .contact_mask_o     (contact_mask_o),
    .stance_o           (stance),
    .swing_o            (swing),
    .gait_segment_o     (gait_segment_o),
    .last_row_o         (last_row_o)
  );

  // Progress values are per leg and repeated on every row of an item.
  assign stance_progress_0_o = stance[0];
  assign stance_progress_1_o = stance[1];
  assign stance_progress_2_o = stance[2];
  assign stance_progress_3_o = stance[3];
  assign swing_progress_0_o  = swing[0];
  assign swing_progress_1_o  = swing[1];
  assign swing_progress_2_o  = swing[2];
  assign swing_progress_3_o  = swing[3];

  // An accepted request keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  // While rows remain to be emitted the sequencer must still be busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      result_valid_o && !last_row_o |-> busy)
    else $error("sequencer went idle before the final row");

  // A burst of result beats starts at row zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(result_valid_o) |-> row_index_o == '0)
    else $error("result burst did not start at row zero");

  // Rows within a burst are consecutive and without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      result_valid_o && !last_row_o |=>
        result_valid_o && row_index_o == ROW_OUT_W'($past(row_index_o) + 1'b1))
    else $error("result rows not consecutive");

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the offset/duration gait contact scheduler.
`timescale 1ns / 1ps

module tb;
  import odgs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 310;
  localparam int unsigned SETTLE_CYCLES = 400;

  // One horizon row as it leaves the block.
  typedef struct packed {
    logic [ROW_OUT_W-1:0]             row;
    logic [LEG_COUNT-1:0]             mask;
    logic [LEG_COUNT-1:0][FRAC_W-1:0] stance;
    logic [LEG_COUNT-1:0][FRAC_W-1:0] swing;
    logic [SEG_OUT_W-1:0]             segment;
    logic                             last;
  } horizon_row_t;

  // Keeps its own copy of the configuration, turns every accepted iteration count into
  // the horizon rows the block must produce, and checks the rows as they come out.
  class contact_row_board;
    logic [SEG_W-1:0] seg_cfg;
    logic [IPS_W-1:0] ips_cfg;
    logic [CFG_W-1:0] off_cfg;
    logic [CFG_W-1:0] dur_cfg;
    horizon_row_t     expected_rows[$];
    int unsigned      errors;

    function new();
      seg_cfg = 6'd10;
      ips_cfg = 10'd1;
      off_cfg = '0;
      dur_cfg = '0;
      errors  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SEGMENTS:  seg_cfg = data[SEG_W-1:0];
        REG_IPS:       ips_cfg = data[IPS_W-1:0];
        REG_OFFSETS:   off_cfg = data;
        REG_DURATIONS: dur_cfg = data;
        default: ;
      endcase
    endfunction

    function longint unsigned wrap_sub(longint unsigned a, longint unsigned b,
                                       longint unsigned m);
      return (a >= b) ? a - b : a + m - b;
    endfunction

    // Q0.16 share of p in a phase of length len; a full phase clips to all ones.
    function longint unsigned phase_fraction(longint unsigned p, longint unsigned len);
      longint unsigned q;
      if (len == 0 || p > len) return 0;
      q = (p << FRAC_W) / len;
      return (q > 65535) ? 65535 : q;
    endfunction

    function void note_iteration(logic [IT_W-1:0] iteration);
      longint unsigned n, ips, period, r, seg, dlen, po, ps, t;
      longint unsigned off[LEG_COUNT];
      longint unsigned dur[LEG_COUNT];
      horizon_row_t    row;
      n = seg_cfg;
      if (n == 0) n = 1;
      if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
      ips = (ips_cfg == 0) ? 1 : ips_cfg;
      period = ips * n;
      r = iteration % period;
      seg = r / ips;
      row = '0;
      for (int j = 0; j < LEG_COUNT; j++) begin
        off[j] = off_cfg[LEG_FIELD_W*j +: LEG_FIELD_W] % n;
        dur[j] = dur_cfg[LEG_FIELD_W*j +: LEG_FIELD_W];
        if (dur[j] > n) dur[j] = n;
        dlen = dur[j] * ips;
        po = wrap_sub(r, off[j] * ips, period);
        ps = wrap_sub(po, dlen % period, period);
        row.stance[j] = FRAC_W'(phase_fraction(po, dlen));
        row.swing[j]  = FRAC_W'(phase_fraction(ps, period - dlen));
      end
      row.segment = SEG_OUT_W'(seg);
      for (longint unsigned i = 0; i < n; i++) begin
        t = (i + seg) % n;
        row.row  = ROW_OUT_W'(i);
        row.last = (i + 1 == n);
        row.mask = '0;
        for (int j = 0; j < LEG_COUNT; j++) begin
          if (wrap_sub(t, off[j], n) < dur[j]) row.mask[j] = 1'b1;
        end
        expected_rows.push_back(row);
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_row(horizon_row_t got);
      horizon_row_t want;
      if (expected_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual row %0d", $time,
                 got.row);
        return;
      end
      want = expected_rows.pop_front();
      compare_field("row_index", want.row, got.row);
      compare_field("contact_mask", want.mask, got.mask);
      for (int j = 0; j < LEG_COUNT; j++) begin
        compare_field($sformatf("stance_progress_%0d", j), want.stance[j], got.stance[j]);
        compare_field($sformatf("swing_progress_%0d", j), want.swing[j], got.swing[j]);
      end
      compare_field("gait_segment", want.segment, got.segment);
      compare_field("last_row", want.last, got.last);
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_SEGMENTS;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IT_W-1:0]      current_iteration_i = '0;
  logic                 result_valid_o;
  logic [ROW_OUT_W-1:0] row_index_o;
  logic [LEG_COUNT-1:0] contact_mask_o;
  logic [FRAC_W-1:0]    stance_progress_0_o, stance_progress_1_o;
  logic [FRAC_W-1:0]    stance_progress_2_o, stance_progress_3_o;
  logic [FRAC_W-1:0]    swing_progress_0_o, swing_progress_1_o;
  logic [FRAC_W-1:0]    swing_progress_2_o, swing_progress_3_o;
  logic [SEG_OUT_W-1:0] gait_segment_o;
  logic                 last_row_o;

  contact_row_board     sb;
  horizon_row_t         seen_row;
  int unsigned          items_sent = 0;
  int unsigned          cycle_count = 0;
  bit                   steady = 1'b0;

  // Effective configuration as last written, used only to aim iteration counts at the
  // edges of the stance and swing phases and into the first three gait cycles.
  int unsigned          eff_n = 10;
  int unsigned          eff_ips = 1;
  logic [CFG_W-1:0]     cur_off = '0;
  logic [CFG_W-1:0]     cur_dur = '0;

  offset_duration_gait_scheduler u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .start               (start),
    .busy                (busy),
    .current_iteration_i (current_iteration_i),
    .result_valid_o      (result_valid_o),
    .row_index_o         (row_index_o),
    .contact_mask_o      (contact_mask_o),
    .stance_progress_0_o (stance_progress_0_o),
    .stance_progress_1_o (stance_progress_1_o),
    .stance_progress_2_o (stance_progress_2_o),
    .stance_progress_3_o (stance_progress_3_o),
    .swing_progress_0_o  (swing_progress_0_o),
    .swing_progress_1_o  (swing_progress_1_o),
    .swing_progress_2_o  (swing_progress_2_o),
    .swing_progress_3_o  (swing_progress_3_o),
    .gait_segment_o      (gait_segment_o),
    .last_row_o          (last_row_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor. The block updates its outputs with nonblocking assignments, so the
  // values read here at the edge are the ones that were on the ports during the cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      seen_row.row     = row_index_o;
      seen_row.mask    = contact_mask_o;
      seen_row.stance  = {stance_progress_3_o, stance_progress_2_o,
                          stance_progress_1_o, stance_progress_0_o};
      seen_row.swing   = {swing_progress_3_o, swing_progress_2_o,
                          swing_progress_1_o, swing_progress_0_o};
      seen_row.segment = gait_segment_o;
      seen_row.last    = last_row_o;
      sb.check_row(seen_row);
    end
  end

  // Watchdog. The slowest legal run, about 310 items plus the longest sender gaps, stays
  // well under a third of this limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("offset_duration_gait_scheduler regression: fail");
    $finish;
  end

  // Waits until every predicted row has been seen and the block has gone idle. Every
  // item yields at least one row and busy drops no later than the last row appears, so
  // nothing can be in flight after this.
  task automatic wait_drained();
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    sb.write_register(idx, data);
  endtask

  // Writes all four registers back to back; the write enable is lowered only after the
  // last one so it never sees two assignments in the same step.
  task automatic configure(input logic [CFG_W-1:0] seg_d, input logic [CFG_W-1:0] ips_d,
                           input logic [CFG_W-1:0] off_d, input logic [CFG_W-1:0] dur_d);
    put_register(REG_SEGMENTS, seg_d);
    put_register(REG_IPS, ips_d);
    put_register(REG_OFFSETS, off_d);
    put_register(REG_DURATIONS, dur_d);
    cfg_we_i <= 1'b0;
    eff_n = seg_d[SEG_W-1:0];
    if (eff_n == 0) eff_n = 1;
    if (eff_n > MAX_SEGMENTS_DEF) eff_n = MAX_SEGMENTS_DEF;
    eff_ips = (ips_d[IPS_W-1:0] == 0) ? 1 : ips_d[IPS_W-1:0];
    cur_off = off_d;
    cur_dur = dur_d;
    @(posedge clk_i);
  endtask

  // Offers one iteration count and holds it until the block takes it. Outside the
  // steady stretch the sender sometimes idles first: mostly a few cycles, sometimes long
  // enough to land anywhere in the block's busy window, and now and then until every
  // outstanding row has come back.
  task automatic send_item(input logic [IT_W-1:0] iteration);
    int unsigned roll;
    roll = $urandom_range(99);
    if (!steady && roll < 32) begin
      start <= 1'b0;
      if (roll < 3) begin
        wait_drained();
      end else if (roll < 10) begin
        repeat ($urandom_range(20, 450)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    start               <= 1'b1;
    current_iteration_i <= iteration;
    do @(posedge clk_i); while (busy);
    sb.note_iteration(iteration);
    items_sent++;
  endtask

  task automatic end_phase();
    start <= 1'b0;
    wait_drained();
  endtask

  // Picks a count that lands on a stance start, a stance end, one step past the start or
  // one step short of the end, for a random leg under the current configuration.
  function automatic logic [IT_W-1:0] phase_edge_iteration();
    int unsigned     leg;
    longint unsigned period, o, d, base, k;
    leg    = $urandom_range(LEG_COUNT - 1);
    period = longint'(eff_ips) * eff_n;
    o      = cur_off[LEG_FIELD_W*leg +: LEG_FIELD_W] % eff_n;
    d      = cur_dur[LEG_FIELD_W*leg +: LEG_FIELD_W];
    if (d > eff_n) d = eff_n;
    case ($urandom_range(3))
      0: base = o * eff_ips;
      1: base = (o + d) * eff_ips;
      2: base = o * eff_ips + 1;
      default: base = (o + d) * eff_ips + period - 1;
    endcase
    base = base % period;
    k = longint'($urandom) % (64'h1_0000_0000 / period);
    return IT_W'(k * period + base);
  endfunction

  function automatic logic [IT_W-1:0] random_iteration();
    case ($urandom_range(7))
      0, 1: return $urandom;
      2: return $urandom_range(0, 3 * eff_ips * eff_n);
      3: return ~IT_W'($urandom_range(0, 3));
      default: return phase_edge_iteration();
    endcase
  endfunction

  // Random configuration that leans on the corners: zero and oversized segment counts,
  // zero and largest iteration counts, and durations of zero, exactly the cycle, and
  // beyond it. Unused upper bits of every write carry noise, which the block must drop.
  task automatic random_config();
    int unsigned      n_raw, n_use, ips_raw, d;
    logic [CFG_W-1:0] durs;
    case ($urandom_range(9))
      0: n_raw = 0;
      1: n_raw = $urandom_range(33, 63);
      2: n_raw = MAX_SEGMENTS_DEF;
      3: n_raw = 1;
      default: n_raw = $urandom_range(2, 31);
    endcase
    n_use = (n_raw == 0) ? 1 : (n_raw > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : n_raw;
    case ($urandom_range(7))
      0: ips_raw = 0;
      1: ips_raw = 1023;
      2: ips_raw = 1;
      3: ips_raw = $urandom_range(2, 8);
      default: ips_raw = $urandom_range(1, 1023);
    endcase
    for (int leg = 0; leg < LEG_COUNT; leg++) begin
      case ($urandom_range(5))
        0: d = 0;
        1: d = n_use;
        2: d = $urandom_range(n_use, 63);
        default: d = $urandom_range(0, n_use);
      endcase
      durs[LEG_FIELD_W*leg +: LEG_FIELD_W] = LEG_FIELD_W'(d);
    end
    if ($urandom_range(7) == 0) durs = CFG_W'($urandom);
    configure((CFG_W'($urandom) & 24'hFFFFC0) | CFG_W'(n_raw),
              (CFG_W'($urandom) & 24'hFFFC00) | CFG_W'(ips_raw),
              CFG_W'($urandom), durs);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: ten segments, all durations zero, so every stance phase has
    // zero length and reports no progress.
    send_item(32'h0000_0000);
    send_item(32'hFFFF_FFFF);
    send_item(32'h5555_5555);
    end_phase();

    // Four segments of three iterations. Leg 2 spans the whole cycle (empty swing) and
    // leg 3 never stands (empty stance). Count 6 ends the swing of leg 1 at exactly
    // one full phase, which must clip to all ones.
    configure(24'd4, 24'd3, {6'd0, 6'd1, 6'd2, 6'd3}, {6'd0, 6'd4, 6'd1, 6'd2});
    send_item(32'd0);
    send_item(32'd6);
    send_item(32'd9);
    send_item(32'd11);
    send_item(32'd12);
    send_item(32'hAAAA_AAAA);
    end_phase();

    // Zero segments and zero iterations per segment both act as one; offsets of 63 fold
    // to zero and durations of 63 clip to the one-segment cycle.
    configure(24'hFFFFC0, 24'hFFFC00, 24'hFFFFFF, 24'hFFFFFF);
    send_item(32'd0);
    send_item(32'd7);
    send_item(32'hFFFF_FFFF);
    end_phase();

    // Oversized segment count clips to the maximum with the largest iteration count,
    // giving the longest period. Offsets beyond the cycle fold, durations beyond clip.
    configure(24'h00003F, 24'd1023, {6'd5, 6'd33, 6'd40, 6'd63}, {6'd0, 6'd16, 6'd32, 6'd63});
    send_item(32'd0);
    send_item(32'd32735);
    send_item(32'd32736);
    send_item(32'd5115);
    send_item(32'hFFFF_FFFF);
    end_phase();

    // Smallest regular cycle: one segment of one iteration, no stance at all.
    configure(24'd1, 24'd1, 24'd0, 24'd0);
    send_item(32'd3);
    send_item(32'h8000_0000);
    end_phase();

    // Random phases. The first one runs with no sender idling at all so the block sees
    // requests offered back to back for a long stretch.
    steady = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      random_config();
      repeat (steady ? 40 : $urandom_range(8, 30)) begin
        send_item(random_iteration());
      end
      end_phase();
      steady = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("offset_duration_gait_scheduler regression: pass");
    end else begin
      $display("offset_duration_gait_scheduler regression: fail");
    end
    $finish;
  end

endmodule
